// ----- design/b64sd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sd_pkg
// Shared types, status codes and symbol lookup for the strict base64 decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BAD_CHAR       = 3'd1,
        ST_DATA_AFTER_PAD = 3'd2,
        ST_EXCESS_PAD     = 3'd3,
        ST_BAD_LENGTH     = 3'd4,
        ST_LEFTOVER       = 3'd5
    } status_t;

    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_END  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic       valid;   // character is in the alphabet
        logic [5:0] value;
    } symbol_t;

    function automatic symbol_t symbol_lookup(input logic [7:0] c);
        symbol_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage
`default_nettype wire

// ----- design/base64_strict_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_strict_decoder_unit
// Strict standard-alphabet base64 decoder, one text character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one item per transfer: s_command = 0 with a text
//   character in s_text_char, or s_command = 1 to close the text and run the
//   final checks. Whitespace and '=' give no result; each data symbol that
//   completes eight gathered bits gives one decoded byte on the m_
//   channel; the end item always gives one status item (m_is_final = 1).
//   A nonzero m_status tells the consumer to drop the bytes of that stream.
//   A result reaches the output register in the cycle after its transfer.
//   Throughput: one item per cycle while s_ready is high; the only state
//   update is a table lookup and a 6-bit shift, done in the transfer cycle.
//   When the receiver stalls, the pending result stays in the output
//   register and s_ready holds low only while that register is full and not
//   being drained; an item that yields no result still needs a free slot.
//   Reset (aresetn low, synchronous) clears the bit buffer, counters, kept
//   error and the output valid flag. An end item clears all decode state.
// ----------------------------------------------------------------------------
module base64_strict_decoder_unit
    import b64sd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [7:0] s_text_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_is_final,
    output logic [2:0]      m_status
);

    logic [11:0] buf_reg,   buf_next;
    logic [2:0]  bcnt_reg,  bcnt_next;
    logic [1:0]  sym_reg,   sym_next;
    logic [1:0]  pad_reg,   pad_next;
    status_t     err_reg,   err_next;

    logic        mvalid_reg, mvalid_next;
    logic [7:0]  mbyte_reg,  mbyte_next;
    logic        mfinal_reg, mfinal_next;
    logic [2:0]  mstat_reg,  mstat_next;

    logic        xfer_in;
    logic        emit;
    symbol_t     sym;
    logic [2:0]  bsum;
    logic [11:0] buf_shift;
    logic [2:0]  d3, p3;
    logic [5:0]  left_mask;
    status_t     fin_st;

    assign s_ready = !mvalid_reg || m_ready;
    assign xfer_in = s_valid && s_ready;
    assign sym     = symbol_lookup(s_text_char);
    assign buf_shift = {buf_reg[5:0], sym.value};
    assign bsum    = bcnt_reg - 3'd2;   // (count + 6) - 8, valid when a byte falls out
    assign d3      = {1'b0, sym_reg};
    assign p3      = {1'b0, pad_reg};

    always_comb begin
        unique case (bcnt_reg)
            3'd2:    left_mask = 6'b000011;
            3'd4:    left_mask = 6'b001111;
            3'd6:    left_mask = 6'b111111;
            default: left_mask = 6'b000000;
        endcase
    end

    // final checks, first failing one wins
    always_comb begin
        fin_st = err_reg;
        if (err_reg == ST_OK) begin
            if (sym_reg == 2'd1) begin
                fin_st = ST_BAD_LENGTH;
            end else if (pad_reg != 2'd0 &&
                         (((d3 + p3) & 3'd3) != 3'd0 || p3 != 3'd4 - d3)) begin
                fin_st = ST_BAD_LENGTH;
            end else if ((buf_reg[5:0] & left_mask) != 6'd0) begin
                fin_st = ST_LEFTOVER;
            end
        end
    end

    always_comb begin
        buf_next    = buf_reg;
        bcnt_next   = bcnt_reg;
        sym_next    = sym_reg;
        pad_next    = pad_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        mvalid_next = mvalid_reg && !m_ready;
        mbyte_next  = mbyte_reg;
        mfinal_next = mfinal_reg;
        mstat_next  = mstat_reg;

        if (xfer_in) begin
            if (s_command == CMD_END) begin
                buf_next    = '0;
                bcnt_next   = '0;
                sym_next    = '0;
                pad_next    = '0;
                err_next    = ST_OK;
                mvalid_next = 1'b1;
                mbyte_next  = 8'd0;
                mfinal_next = 1'b1;
                mstat_next  = fin_st;
            end else if (err_reg != ST_OK) begin
                // characters after an error are dropped
            end else if (s_text_char == PAD_CHAR) begin
                if (pad_reg >= 2'd2) begin
                    err_next = ST_EXCESS_PAD;
                    pad_next = 2'd3;
                end else begin
                    pad_next = pad_reg + 2'd1;
                end
            end else if (is_space(s_text_char)) begin
                // skipped
            end else if (pad_reg != 2'd0) begin
                err_next = ST_DATA_AFTER_PAD;
            end else if (!sym.valid) begin
                err_next = ST_BAD_CHAR;
            end else begin
                sym_next = sym_reg + 2'd1;
                buf_next = buf_shift;
                if (bcnt_reg >= 3'd2) begin
                    emit      = 1'b1;
                    bcnt_next = bsum;
                end else begin
                    bcnt_next = bcnt_reg + 3'd6;
                end
            end
            if (emit) begin
                mvalid_next = 1'b1;
                mfinal_next = 1'b0;
                mstat_next  = ST_OK;
                unique case (bsum)
                    3'd2:    mbyte_next = buf_shift[9:2];
                    3'd4:    mbyte_next = buf_shift[11:4];
                    default: mbyte_next = buf_shift[7:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg    <= '0;
            bcnt_reg   <= '0;
            sym_reg    <= '0;
            pad_reg    <= '0;
            err_reg    <= ST_OK;
            mvalid_reg <= 1'b0;
        end else begin
            buf_reg    <= buf_next;
            bcnt_reg   <= bcnt_next;
            sym_reg    <= sym_next;
            pad_reg    <= pad_next;
            err_reg    <= err_next;
            mvalid_reg <= mvalid_next;
        end
        mbyte_reg  <= mbyte_next;
        mfinal_reg <= mfinal_next;
        mstat_reg  <= mstat_next;
    end

    assign m_valid    = mvalid_reg;
    assign m_out_byte = mbyte_reg;
    assign m_is_final = mfinal_reg;
    assign m_status   = mstat_reg;

    // an end transfer leaves no decode state behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        xfer_in && s_command == CMD_END |=> bcnt_reg == 3'd0 && sym_reg == 2'd0
            && pad_reg == 2'd0 && err_reg == ST_OK && buf_reg == 12'd0)
        else $error("decode state not cleared after end transfer");

    // data bytes carry ok status, status items carry a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_final |-> m_status == ST_OK)
        else $error("data byte with nonzero status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_final |-> m_out_byte == 8'd0)
        else $error("status item with nonzero byte");

    // leftover bit count is always even and below eight
    assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg[0] == 1'b0)
        else $error("odd bit count");

endmodule
`default_nettype wire
